[design/raot_pkg.sv]
package raot_pkg;

   // Field widths
   localparam int STATE_W   = 16;
   localparam int LEN_W     = 17;
   localparam int LCM_W     = 64;
   localparam int ADDR_W    = 16;
   localparam int MAP_DEPTH = 65536;
   localparam int SHIFT_W   = 5;
   localparam int DIV_CNT_W = 5;
   localparam int MUL_CNT_W = 2;
   localparam int PROD_W    = LCM_W + LEN_W;

   localparam logic [LEN_W-1:0]  CNT_MAX = 17'h1FFFF;
   localparam logic [LCM_W-1:0]  LCM_ONE = 64'd1;

   // Opcodes
   localparam logic OP_TRACE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Request and response words
   typedef struct packed {
      logic              opcode;
      logic [STATE_W-1:0] start_state;
      logic [LEN_W-1:0]   query_length;
   } req_type;

   typedef struct packed {
      logic              was_visited;
      logic [LEN_W-1:0]   orbit_length;
      logic [LEN_W-1:0]   orbits_found;
      logic [LEN_W-1:0]   longest_orbit;
      logic [LCM_W-1:0]   period_lcm;
      logic              lcm_saturated;
      logic [LEN_W-1:0]   bin_count;
   } rsp_type;

   // Tracer sequencer
   typedef enum logic [2:0] {
      T_CLEAR,
      T_IDLE,
      T_LOOKUP,
      T_WALK,
      T_HREAD,
      T_HWRITE,
      T_LCM,
      T_RESP
   } tracer_state_type;

   // LCM unit sequencer
   typedef enum logic [1:0] {
      L_IDLE,
      L_GCD,
      L_DIV,
      L_MUL
   } lcm_state_type;

   // Tracer to LCM unit
   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } lcm_cmd_type;

   // LCM unit to tracer
   typedef struct packed {
      logic             busy;
      logic [LCM_W-1:0] value;
      logic             saturated;
   } lcm_sts_type;

endpackage

[design/reversible_automaton_orbit_tracer.sv]
// Orbit tracer for a second-order parity automaton on a periodic SIDE^3 cube.
// After reset the block sweeps both 65536-entry maps (visited flags and the
// length histogram) to zero, one entry per cycle, so req_ready stays low
// until the sweep ends. A histogram query goes through T_LOOKUP to T_RESP,
// and so does a trace of an already visited state. A new orbit of length
// L goes through T_WALK, one visited map write per automaton step, then
// T_HREAD and T_HWRITE for the histogram update, then the LCM fold: a binary
// GCD, a restoring divide and a 16-bit slice multiply.
// Over all seeds the walks visit each lattice state once. One command is
// worked on at a time; a finished response word sits in an output register,
// so the next command can be taken while it waits.
module reversible_automaton_orbit_tracer
   import raot_pkg::*;
#(
   parameter int SIDE = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CELLS = SIDE * SIDE * SIDE;
   localparam int NBITS = 2 * CELLS;
   localparam logic [LEN_W-1:0]   LIMIT = LEN_W'(1) << NBITS;
   localparam logic [STATE_W-1:0] SMASK = STATE_W'(LIMIT - LEN_W'(1));

   tracer_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [LEN_W-1:0]     total_ff, total_in;
   logic [LEN_W-1:0]     longest_ff, longest_in;
   logic                 op_ff, op_in;
   logic [STATE_W-1:0]   start_ff, start_in;
   logic [STATE_W-1:0]   lat_ff, lat_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic                 was_ff, was_in;
   logic [LEN_W-1:0]     olen_ff, olen_in;
   logic [LEN_W-1:0]     bin_ff, bin_in;

   logic [STATE_W-1:0]   lat_next;
   logic [LEN_W-1:0]     cnt_inc;
   logic                 slot_free;

   logic                 map_we;
   logic [ADDR_W-1:0]    map_addr;
   logic                 map_wdata;
   logic                 map_rdata;
   logic                 hist_we;
   logic [ADDR_W-1:0]    hist_addr;
   logic [LEN_W-1:0]     hist_wdata;
   logic [LEN_W-1:0]     hist_rdata;

   lcm_cmd_type          lcm_cmd;
   lcm_sts_type          lcm_sts;

   // One automaton step: new now bit = XOR of six neighbors and own prev bit
   for (genvar gz = 0; gz < SIDE; gz++) begin : g_z
      for (genvar gy = 0; gy < SIDE; gy++) begin : g_y
         for (genvar gx = 0; gx < SIDE; gx++) begin : g_x
            localparam int I  = gx + SIDE * gy + SIDE * SIDE * gz;
            localparam int XP = ((gx + 1) % SIDE) + SIDE * gy + SIDE * SIDE * gz;
            localparam int XM = ((gx + SIDE - 1) % SIDE) + SIDE * gy + SIDE * SIDE * gz;
            localparam int YP = gx + SIDE * ((gy + 1) % SIDE) + SIDE * SIDE * gz;
            localparam int YM = gx + SIDE * ((gy + SIDE - 1) % SIDE) + SIDE * SIDE * gz;
            localparam int ZP = gx + SIDE * gy + SIDE * SIDE * ((gz + 1) % SIDE);
            localparam int ZM = gx + SIDE * gy + SIDE * SIDE * ((gz + SIDE - 1) % SIDE);
            assign lat_next[2*I] = lat_ff[2*XP] ^ lat_ff[2*XM] ^ lat_ff[2*YP]
                                 ^ lat_ff[2*YM] ^ lat_ff[2*ZP] ^ lat_ff[2*ZM]
                                 ^ lat_ff[2*I+1];
            assign lat_next[2*I+1] = lat_ff[2*I];
         end
      end
   end
   if (NBITS < STATE_W) begin : g_pad
      assign lat_next[STATE_W-1:NBITS] = '0;
   end

   assign cnt_inc   = cnt_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Visited flags, one per lattice state
   raot_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
      .clock (clock),
      .we    (map_we),
      .addr  (map_addr),
      .wdata (map_wdata),
      .rdata (map_rdata)
   );

   // Orbit length histogram
   raot_ram #(.WIDTH(LEN_W), .DEPTH(MAP_DEPTH)) u_hist (
      .clock (clock),
      .we    (hist_we),
      .addr  (hist_addr),
      .wdata (hist_wdata),
      .rdata (hist_rdata)
   );

   raot_lcm u_lcm (
      .clock (clock),
      .reset (reset),
      .cmd   (lcm_cmd),
      .sts   (lcm_sts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         longest_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         longest_ff   <= longest_in;
      end
      rsp_ff   <= rsp_in;
      op_ff    <= op_in;
      start_ff <= start_in;
      lat_ff   <= lat_in;
      cnt_ff   <= cnt_in;
      was_ff   <= was_in;
      olen_ff  <= olen_in;
      bin_ff   <= bin_in;
   end

   // Sequencer: next state, memory ports and datapath updates
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      total_in     = total_ff;
      longest_in   = longest_ff;
      op_in        = op_ff;
      start_in     = start_ff;
      lat_in       = lat_ff;
      cnt_in       = cnt_ff;
      was_in       = was_ff;
      olen_in      = olen_ff;
      bin_in       = bin_ff;

      req_ready    = 1'b0;
      map_we       = 1'b0;
      map_addr     = lat_ff;
      map_wdata    = 1'b1;
      hist_we      = 1'b0;
      hist_addr    = cnt_ff[ADDR_W-1:0];
      hist_wdata   = (hist_rdata == CNT_MAX) ? hist_rdata : hist_rdata + 1'b1;
      lcm_cmd.start = 1'b0;
      lcm_cmd.len   = cnt_ff;

      unique case (state_ff)
         T_CLEAR: begin
            map_we      = 1'b1;
            map_addr    = clr_addr_ff;
            map_wdata   = 1'b0;
            hist_we     = 1'b1;
            hist_addr   = clr_addr_ff;
            hist_wdata  = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == '1) begin
               state_in = T_IDLE;
            end
         end
         T_IDLE: begin
            // read both maps speculatively at the request's address
            req_ready = 1'b1;
            map_addr  = req_data.start_state & SMASK;
            hist_addr = req_data.query_length[ADDR_W-1:0];
            if (req_valid) begin
               op_in    = req_data.opcode;
               start_in = req_data.start_state & SMASK;
               state_in = T_LOOKUP;
            end
         end
         T_LOOKUP: begin
            was_in  = 1'b0;
            olen_in = '0;
            bin_in  = '0;
            priority if (op_ff == OP_QUERY) begin
               bin_in   = hist_rdata;
               state_in = T_RESP;
            end else if (map_rdata) begin
               was_in   = 1'b1;
               state_in = T_RESP;
            end else begin
               lat_in   = start_ff;
               cnt_in   = '0;
               state_in = T_WALK;
            end
         end
         T_WALK: begin
            // mark, step, count until the start state comes back or the count reaches LIMIT
            map_we = 1'b1;
            lat_in = lat_next;
            cnt_in = cnt_inc;
            if (lat_next == start_ff || cnt_inc == LIMIT) begin
               state_in = T_HREAD;
            end
         end
         T_HREAD: begin
            state_in = T_HWRITE;
         end
         T_HWRITE: begin
            hist_we       = 1'b1;
            olen_in       = cnt_ff;
            lcm_cmd.start = 1'b1;
            if (total_ff != CNT_MAX) begin
               total_in = total_ff + 1'b1;
            end
            if (cnt_ff > longest_ff) begin
               longest_in = cnt_ff;
            end
            state_in = T_LCM;
         end
         T_LCM: begin
            if (!lcm_sts.busy) begin
               state_in = T_RESP;
            end
         end
         T_RESP: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.was_visited   = was_ff;
               rsp_in.orbit_length  = olen_ff;
               rsp_in.orbits_found  = total_ff;
               rsp_in.longest_orbit = longest_ff;
               rsp_in.period_lcm    = lcm_sts.value;
               rsp_in.lcm_saturated = lcm_sts.saturated;
               rsp_in.bin_count     = bin_ff;
               state_in             = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/raot_ram.sv]
module raot_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port, registered read, read returns old data on a write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[design/raot_lcm.sv]
module raot_lcm
   import raot_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  lcm_cmd_type cmd,
   output lcm_sts_type sts
);

   lcm_state_type         state_ff, state_in;
   logic [LCM_W-1:0]      lcm_ff, lcm_in;
   logic                  sat_ff, sat_in;
   logic [LCM_W-1:0]      u_ff, u_in;
   logic [LEN_W-1:0]      v_ff, v_in;
   logic [SHIFT_W-1:0]    k_ff, k_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [LEN_W-1:0]      dvs_ff, dvs_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [LEN_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  dcnt_ff, dcnt_in;
   logic [MUL_CNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;

   logic [LCM_W-1:0]      v_wide;
   logic [LCM_W-1:0]      u_minus_v;
   logic [LEN_W-1:0]      v_minus_u;
   logic [LEN_W-1:0]      gcd_base;
   logic [LEN_W:0]        trial;
   logic [15:0]           lcm_slice;
   logic [LEN_W+16:0]     part;

   assign v_wide    = LCM_W'(v_ff);
   assign u_minus_v = u_ff - v_wide;
   assign v_minus_u = v_ff - u_ff[LEN_W-1:0];
   assign gcd_base  = (u_ff == '0) ? v_ff : u_ff[LEN_W-1:0];
   assign trial     = {rem_ff, quo_ff[LEN_W-1]};
   assign lcm_slice = lcm_ff[{mcnt_ff, 4'b0000} +: 16];
   assign part      = lcm_slice * quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         lcm_ff   <= LCM_ONE;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcm_ff   <= lcm_in;
         sat_ff   <= sat_in;
      end
      u_ff    <= u_in;
      v_ff    <= v_in;
      k_ff    <= k_in;
      len_ff  <= len_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      mcnt_ff <= mcnt_in;
      acc_ff  <= acc_in;
   end

   // Binary GCD, then restoring divide len/gcd, then 16-bit slice multiply
   always_comb begin
      state_in = state_ff;
      lcm_in   = lcm_ff;
      sat_in   = sat_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      k_in     = k_ff;
      len_in   = len_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      mcnt_in  = mcnt_ff;
      acc_in   = acc_ff;

      unique case (state_ff)
         L_IDLE: begin
            // saturated LCM stays put, zero length never folds
            if (cmd.start && !sat_ff && cmd.len != '0) begin
               u_in     = lcm_ff;
               v_in     = cmd.len;
               k_in     = '0;
               len_in   = cmd.len;
               state_in = L_GCD;
            end
         end
         L_GCD: begin
            priority if (u_ff == '0 || v_ff == '0) begin
               dvs_in   = gcd_base << k_ff;
               rem_in   = '0;
               quo_in   = len_ff;
               dcnt_in  = '0;
               state_in = L_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff >= v_wide) begin
               u_in = u_minus_v >> 1;
            end else begin
               v_in = v_minus_u >> 1;
            end
         end
         L_DIV: begin
            // dividend shifts out of quo, quotient bits shift in
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = LEN_W'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[LEN_W-2:0], 1'b1};
            end else begin
               rem_in = trial[LEN_W-1:0];
               quo_in = {quo_ff[LEN_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CNT_W'(LEN_W - 1)) begin
               acc_in   = '0;
               mcnt_in  = '1;
               state_in = L_MUL;
            end
         end
         L_MUL: begin
            // most significant slice first
            acc_in  = {acc_ff[PROD_W-17:0], 16'h0000} + PROD_W'(part);
            mcnt_in = mcnt_ff - 1'b1;
            if (mcnt_ff == '0) begin
               if (acc_in[PROD_W-1:LCM_W] != '0) begin
                  lcm_in = '1;
                  sat_in = 1'b1;
               end else begin
                  lcm_in = acc_in[LCM_W-1:0];
               end
               state_in = L_IDLE;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   assign sts.busy      = (state_ff != L_IDLE);
   assign sts.value     = lcm_ff;
   assign sts.saturated = sat_ff;

endmodule

[design/raot_checker.sv]
module raot_checker
   import raot_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // The clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // A skipped trace reports no orbit and no bin
   a_skip_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_visited |->
         rsp_data.orbit_length == '0 && rsp_data.bin_count == '0)
      else $error("visited start reported an orbit");

   // A new orbit never exceeds the longest one reported with it
   a_longest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.orbit_length != '0 |->
         rsp_data.orbit_length <= rsp_data.longest_orbit &&
         rsp_data.orbits_found != '0)
      else $error("orbit longer than longest orbit");

   // Saturation pins the LCM at all ones
   a_lcm_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.lcm_saturated |-> rsp_data.period_lcm == '1)
      else $error("saturated LCM not all ones");

endmodule

bind reversible_automaton_orbit_tracer raot_checker u_raot_checker (.*);
